>>> src/mf3_pkg.sv
// Package for the 3x3 minimum filter: register codes and fixed constants.
// No dependencies; imported by the top level.
package mf3_pkg;

    localparam int CFG_BITS    = 10;   // width of the configuration registers
    localparam int DIM_RESET   = 512;  // reset value of both dimension registers
    localparam int DIM_MIN     = 2;    // smallest dimension in use
    localparam int MAX_RESULTS = 4;    // results one pixel can cause
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

>>> src/mf3_line_store.sv
// One line store of the 3x3 minimum filter: simple dual-port synchronous RAM
// with a registered read. No dependencies.
module mf3_line_store #(
    parameter int DEPTH     = 512,
    parameter int DATA_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [DATA_BITS-1:0]         i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [DATA_BITS-1:0]         o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/min_filter_3x3_replicate_top.sv
// 3x3 minimum filter (grey-scale erosion) with edge replication. Pixels enter in raster
// order, one per clock unless the read stage stalls; each pixel is read against two
// line stores (RAMs with a registered read) and the window of the two previous
// columns, and results leave one per clock while i_ready is high, through a four-entry
// result buffer. Most pixels cause one result, the last pixel of a row two, and pixels
// of the last row two or four, so the input stalls while the buffer still holds extra
// results. A pixel is registered in the read stage, and its results are then loaded
// into the result buffer once it is free. A register write restarts the frame.
// Depends on mf3_pkg and mf3_line_store.
module min_filter_3x3_replicate_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_run_last,
    output logic                  o_frame_end,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);
    localparam int W_RESET  = (DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RESET;
    localparam int H_RESET  = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    function automatic logic [PIXEL_BITS-1:0] min2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // ---------------- configuration and position ----------------
    logic [COL_BITS-1:0] r_wlast, n_wlast;
    logic [ROW_BITS-1:0] r_hlast, n_hlast;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;
    logic                in_acc;

    always_comb begin
        n_wlast = r_wlast;
        n_hlast = r_hlast;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    if (32'(i_cfg_data) < DIM_MIN) begin
                        n_wlast = COL_BITS'(DIM_MIN - 1);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        n_wlast = COL_BITS'(MAX_WIDTH - 1);
                    end else begin
                        n_wlast = COL_BITS'(32'(i_cfg_data) - 1);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (32'(i_cfg_data) < DIM_MIN) begin
                        n_hlast = ROW_BITS'(DIM_MIN - 1);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        n_hlast = ROW_BITS'(MAX_HEIGHT - 1);
                    end else begin
                        n_hlast = ROW_BITS'(32'(i_cfg_data) - 1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= COL_BITS'(W_RESET - 1);
            r_hlast <= ROW_BITS'(H_RESET - 1);
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_wlast <= n_wlast;
            r_hlast <= n_hlast;
            if (i_cfg_we) begin
                // restart the frame
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (r_col == r_wlast) begin
                    r_col <= '0;
                    r_row <= (r_row == r_hlast) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // ---------------- read stage: pixel waits for line store data ----------------
    logic                  r_s1_valid;
    logic [COL_BITS-1:0]   r_s1_col;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic                  r_s1_rge2;   // row >= 2: the two-up line is real
    logic                  r_s1_first;  // column 0: seed the window
    logic                  r_s1_emit;
    logic                  r_s1_endc;
    logic                  r_s1_lastr;
    logic                  s1_fire;
    logic                  buf_free;
    logic [PIXEL_BITS-1:0] rd_one, rd_two;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col   <= r_col;
            r_s1_px    <= i_pixel_in;
            r_s1_rge2  <= (r_row >= ROW_BITS'(2));
            r_s1_first <= (r_col == '0);
            r_s1_emit  <= (r_row != '0) && (r_col != '0);
            r_s1_endc  <= (r_col == r_wlast);
            r_s1_lastr <= (r_row == r_hlast);
        end
    end

    // Read at the new pixel's column; the write-back of the pixel ahead is always
    // at another column (width is at least two), so no forwarding is needed.
    mf3_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PIXEL_BITS)) u_line_one (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd_one)
    );

    mf3_line_store #(.DEPTH(MAX_WIDTH), .DATA_BITS(PIXEL_BITS)) u_line_two (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (rd_one),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd_two)
    );

    // ---------------- window and minimum tree ----------------
    logic [PIXEL_BITS-1:0] r_win [6];
    logic [PIXEL_BITS-1:0] cur0, cur1, cur2;
    logic [PIXEL_BITS-1:0] l0, l1, l2, f0, f1, f2;
    logic [PIXEL_BITS-1:0] res_a, res_b, res_c, res_d;

    assign cur2 = r_s1_px;
    assign cur1 = rd_one;
    assign cur0 = r_s1_rge2 ? rd_two : rd_one;

    assign l0 = min2(cur1, cur2);
    assign l1 = min2(r_win[1], r_win[2]);
    assign l2 = min2(r_win[4], r_win[5]);
    assign f0 = min2(cur0, l0);
    assign f1 = min2(r_win[0], l1);
    assign f2 = min2(r_win[3], l2);

    assign res_a = min2(f2, min2(f1, f0));
    assign res_b = min2(f1, f0);
    assign res_c = min2(l2, min2(l1, l0));
    assign res_d = min2(l1, l0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_fire) begin
            if (r_s1_first) begin
                r_win[3] <= cur0;
                r_win[4] <= cur1;
                r_win[5] <= cur2;
            end else begin
                r_win[3] <= r_win[0];
                r_win[4] <= r_win[1];
                r_win[5] <= r_win[2];
            end
            r_win[0] <= cur0;
            r_win[1] <= cur1;
            r_win[2] <= cur2;
        end
    end

    // ---------------- result buffer ----------------
    logic [PIXEL_BITS-1:0] r_buf [MAX_RESULTS];
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_fend;
    logic                  out_acc;
    logic [CNT_BITS-1:0]   n_load;

    assign out_acc  = o_valid && i_ready;
    assign buf_free = (r_cnt == '0) || ((r_cnt == CNT_BITS'(1)) && i_ready);
    assign s1_fire  = r_s1_valid && buf_free;

    always_comb begin
        n_load = '0;
        if (r_s1_emit) begin
            n_load = CNT_BITS'(1) + CNT_BITS'(r_s1_endc) + CNT_BITS'(r_s1_lastr)
                   + CNT_BITS'(r_s1_endc && r_s1_lastr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s1_fire) begin
            r_cnt <= n_load;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            // pack in output order; without a row end only the bottom-row result follows
            r_buf[0] <= res_a;
            r_buf[1] <= r_s1_endc ? res_b : res_c;
            r_buf[2] <= res_c;
            r_buf[3] <= res_d;
            r_fend   <= r_s1_endc && r_s1_lastr;
        end else if (out_acc) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
        end
    end

    assign o_valid     = (r_cnt != '0);
    assign o_pixel_out = r_buf[0];
    assign o_run_last  = (r_cnt == CNT_BITS'(1));
    assign o_frame_end = (r_cnt == CNT_BITS'(1)) && r_fend;

endmodule

>>> src/mf3_checker.sv
// Port-level checks for the 3x3 minimum filter, bound to the top level.
// Depends on min_filter_3x3_replicate_top and mf3_pkg.
module mf3_checker
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [PIXEL_BITS-1:0] o_pixel_out,
    input logic                  o_run_last,
    input logic                  o_frame_end,
    input logic                  i_cfg_we
);

    // a held result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out) && $stable(o_run_last)
                                && $stable(o_frame_end))
        else $error("result request changed while stalled");

    // frame end only closes a run
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_run_last)
        else $error("frame end without run last");

    // nothing pending and ready for a request right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending after reset");

    // a run that is not done keeps going on the next request
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_last && !i_cfg_we |=> o_valid)
        else $error("run ended without run last");

endmodule

bind min_filter_3x3_replicate_top mf3_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf3_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pixel_out (o_pixel_out),
    .o_run_last  (o_run_last),
    .o_frame_end (o_frame_end),
    .i_cfg_we    (i_cfg_we)
);

>>> sim/min_filter_3x3_replicate_top_tb.sv
// Self-checking testbench for min_filter_3x3_replicate_top: a 3x3 minimum filter with
// edge replication is predicted in a scoreboard class and compared per output pixel.
// Depends on mf3_pkg and the RTL of min_filter_3x3_replicate_top.
module min_filter_3x3_replicate_top_tb;
    import mf3_pkg::*;

    localparam int MAX_DIM = 512;
    localparam int SETTLE  = 8;     // cycles to let a request with no result drain
    localparam int PHASES  = 15;

    typedef struct packed {
        logic [7:0] pixel;
        logic       run_last;
        logic       frame_end;
    } t_eroded_px;

    class erosion_scoreboard;
        bit [7:0]          two_up [MAX_DIM];
        bit [7:0]          one_up [MAX_DIM];
        bit [7:0]          win [6];      // previous column triple, then the one before
        int unsigned       col;
        int unsigned       row;
        bit [CFG_BITS-1:0] width_reg;
        bit [CFG_BITS-1:0] height_reg;
        t_eroded_px        owed_pixels [$];
        int unsigned       errors;
        int unsigned       pixels_in;
        int unsigned       pixels_out;

        function new();
            width_reg  = CFG_BITS'(DIM_RESET);
            height_reg = CFG_BITS'(DIM_RESET);
            col        = 0;
            row        = 0;
        endfunction

        // A write restarts the frame; line stores keep their contents.
        function void write_reg(t_cfg_reg idx, bit [CFG_BITS-1:0] val);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = val;
            end else begin
                height_reg = val;
            end
            col = 0;
            row = 0;
            foreach (win[k]) win[k] = '0;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function bit [7:0] min8(bit [7:0] a, bit [7:0] b);
            return (a < b) ? a : b;
        endfunction

        function void note_pixel(bit [7:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            bit [7:0]    cur [3];
            bit [7:0]    l0, l1, l2, f0, f1, f2;
            t_eroded_px  res [$];

            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            c = (col >= w) ? w - 1 : col;
            r = (row >= h) ? h - 1 : row;
            pixels_in++;

            // Replicate the top edge: rows 0 and 1 have no second row above.
            cur[1] = one_up[c];
            cur[0] = (r >= 2) ? two_up[c] : cur[1];
            cur[2] = px;
            two_up[c] = one_up[c];
            one_up[c] = px;

            // Replicate the left edge into both window columns.
            if (c == 0) begin
                win[0] = cur[0]; win[1] = cur[1]; win[2] = cur[2];
                win[3] = cur[0]; win[4] = cur[1]; win[5] = cur[2];
            end

            if (r >= 1 && c >= 1) begin
                l0 = min8(cur[1], cur[2]);
                l1 = min8(win[1], win[2]);
                l2 = min8(win[4], win[5]);
                f0 = min8(cur[0], l0);
                f1 = min8(win[0], l1);
                f2 = min8(win[3], l2);
                res.push_back('{pixel: min8(f2, min8(f1, f0)), run_last: 1'b0,
                                frame_end: 1'b0});
                if (c == w - 1)
                    res.push_back('{pixel: min8(f1, f0), run_last: 1'b0, frame_end: 1'b0});
                // Bottom row reuses the last input row as its own lower neighbor.
                if (r == h - 1) begin
                    res.push_back('{pixel: min8(l2, min8(l1, l0)), run_last: 1'b0,
                                    frame_end: 1'b0});
                    if (c == w - 1)
                        res.push_back('{pixel: min8(l1, l0), run_last: 1'b0,
                                        frame_end: 1'b1});
                end
            end

            if (c != 0) begin
                win[3] = win[0]; win[4] = win[1]; win[5] = win[2];
                win[0] = cur[0]; win[1] = cur[1]; win[2] = cur[2];
            end

            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end

            if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
            foreach (res[k]) owed_pixels.push_back(res[k]);
        endfunction

        function void check_result(bit [7:0] pix, bit last, bit fend);
            t_eroded_px want;

            pixels_out++;
            if (owed_pixels.size() == 0) begin
                $error("unexpected result: pixel_out=%0d run_last=%0d frame_end=%0d",
                       pix, last, fend);
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            if (want.pixel != pix) begin
                $error("pixel_out: expected %0d, actual %0d", want.pixel, pix);
                errors++;
            end
            if (want.run_last != last) begin
                $error("run_last: expected %0d, actual %0d", want.run_last, last);
                errors++;
            end
            if (want.frame_end != fend) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, fend);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_pixels.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [7:0]          i_pixel_in  = '0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [7:0]          o_pixel_out;
    logic                o_run_last;
    logic                o_frame_end;
    logic                i_cfg_we    = 1'b0;
    logic [0:0]          i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0] i_cfg_data  = '0;

    int gap_pct   = 18;
    int stall_pct = 86;

    erosion_scoreboard sb = new();

    min_filter_3x3_replicate_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("min_filter_3x3_replicate_top: mismatch");
        $finish;
    end

    // Check each accepted result, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_pixel_out, o_run_last, o_frame_end);
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_pixel(input logic [7:0] px);
        int gap;

        gap = 0;
        while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    // Drain the filter, then write both dimension registers back to back.
    task automatic set_dims(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        i_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        sb.write_reg(REG_IMAGE_WIDTH, w);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        sb.write_reg(REG_IMAGE_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0]          corners  [8] = '{8'd0, 8'd255, 8'd255, 8'd0,
                                              8'd255, 8'd0, 8'd0, 8'd255};
        logic [7:0]          lone_min [9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                                              8'hFF, 8'hFF, 8'hFF, 8'hFF};
        logic [7:0]          mixed    [9] = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFE,
                                              8'h7F, 8'h80, 8'h01, 8'hC3};
        logic [CFG_BITS-1:0] w_reg;
        logic [CFG_BITS-1:0] h_reg;
        int                  npix;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers below the minimum clamp to 2x2; two frames check the wrap.
        set_dims(10'd0, 10'd1);
        foreach (corners[k]) send_pixel(corners[k]);
        set_dims(10'd3, 10'd3);
        foreach (lone_min[k]) send_pixel(lone_min[k]);
        set_dims(10'd3, 10'd3);
        foreach (mixed[k]) send_pixel(mixed[k]);

        for (int p = 0; p < PHASES; p++) begin
            if (p < PHASES / 3) begin
                gap_pct   = 18;
                stall_pct = 86;
            end else if (p < 2 * PHASES / 3) begin
                gap_pct   = 86;
                stall_pct = 18;
            end else begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            case (p)
                2: begin
                    // Clamps to the full line store; start the frame, then restart it.
                    w_reg = 10'd1023;
                    h_reg = 10'd2;
                    npix  = 24;
                end
                7: begin
                    // Clamps to the tallest frame; walk its first rows.
                    w_reg = 10'd2;
                    h_reg = 10'd1023;
                    npix  = 24;
                end
                12: begin
                    w_reg = 10'd9;
                    h_reg = 10'd3;
                    npix  = 27;
                end
                default: begin
                    w_reg = CFG_BITS'($urandom_range(6, 2));
                    h_reg = CFG_BITS'($urandom_range(5, 2));
                    if ($urandom_range(3) == 0)
                        npix = $urandom_range(2 * w_reg * h_reg - 1, 1);
                    else
                        npix = w_reg * h_reg * $urandom_range(2, 1);
                end
            endcase
            set_dims(w_reg, h_reg);
            repeat (npix) begin
                case ($urandom_range(7))
                    0:       send_pixel(8'd0);
                    1:       send_pixel(8'd255);
                    default: send_pixel(8'($urandom_range(255)));
                endcase
            end
        end

        i_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Filtered %0d pixels into %0d checked results over %0d settings,",
                 sb.pixels_in, sb.pixels_out, PHASES + 3);
        $display("with register values clamped at both ends, frame restarts and varied stalls.");
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("min_filter_3x3_replicate_top: match");
        end else begin
            $display("min_filter_3x3_replicate_top: mismatch");
        end
        $finish;
    end

endmodule
